// ===== hdl/lrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

  // Item modes.
  localparam logic [1:0] MODE_ACTION = 2'd0;
  localparam logic [1:0] MODE_PROD   = 2'd1;
  localparam logic [1:0] MODE_TOKEN  = 2'd2;

  // Action entry kinds.
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_SHIFT  = 2'd1;
  localparam logic [1:0] KIND_REDUCE = 2'd2;
  localparam logic [1:0] KIND_ACCEPT = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_SHIFTED  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED = 3'd2;
  localparam logic [2:0] ST_ERROR    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam int unsigned ENTRY_W   = 10;
  localparam int unsigned STATE_W   = 8;
  localparam logic [7:0]  REDUCE_CAP = 8'hFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACT_RD,
    S_ACT_EV,
    S_PROD_EV,
    S_POP_EV,
    S_GOTO_EV,
    S_FIN
  } lrp_state_e;

  typedef struct packed {
    logic       latch;
    logic       wr_action;
    logic       wr_prod;
    logic       act_rd;
    logic       goto_rd;
    logic       prod_rd;
    logic       pop;
    logic       push;
    logic       count;
    logic       set_status;
    logic [2:0] status;
    logic       clear;
    logic       out_load;
  } lrp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       inrange;
    logic       sp_full;
    logic       reds_cap;
    logic       prod_bad;
    logic       len_bad;
  } lrp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/lrp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrp_ctrl import lrp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output lrp_cmd_t        cmd_o,
  input  wire lrp_sts_t   sts_i
);

  lrp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = ST_LOADED;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.latch     = 1'b1;
          cmd_o.wr_action = (mode_i == MODE_ACTION);
          cmd_o.wr_prod   = (mode_i == MODE_PROD);
          state_d = (mode_i == MODE_TOKEN) ? S_ACT_RD : S_FIN;
        end
      end
      S_ACT_RD: begin
        cmd_o.act_rd = 1'b1;
        state_d = S_ACT_EV;
      end
      S_ACT_EV: begin
        if (!sts_i.inrange || sts_i.kind == KIND_EMPTY) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ERROR;
          cmd_o.clear      = 1'b1;
          state_d = S_FIN;
        end else if (sts_i.kind == KIND_ACCEPT) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ACCEPTED;
          cmd_o.clear      = 1'b1;
          state_d = S_FIN;
        end else if (sts_i.kind == KIND_SHIFT) begin
          cmd_o.set_status = 1'b1;
          if (sts_i.sp_full) begin
            cmd_o.status = ST_OVERFLOW;
            cmd_o.clear  = 1'b1;
          end else begin
            cmd_o.status = ST_SHIFTED;
            cmd_o.push   = 1'b1;
          end
          state_d = S_FIN;
        end else begin
          if (sts_i.reds_cap || sts_i.prod_bad) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_ERROR;
            cmd_o.clear      = 1'b1;
            state_d = S_FIN;
          end else begin
            cmd_o.prod_rd = 1'b1;
            state_d = S_PROD_EV;
          end
        end
      end
      S_PROD_EV: begin
        if (sts_i.len_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ERROR;
          cmd_o.clear      = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_POP_EV;
        end
      end
      S_POP_EV: begin
        cmd_o.goto_rd = 1'b1;
        state_d = S_GOTO_EV;
      end
      S_GOTO_EV: begin
        if (!sts_i.inrange || sts_i.kind != KIND_SHIFT) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ERROR;
          cmd_o.clear      = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.push  = 1'b1;
          cmd_o.count = 1'b1;
          state_d = S_ACT_RD;
        end
      end
      S_FIN: begin
        // The result register is free once its previous beat has gone.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lrp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrp_datapath import lrp_pkg::*; #(
  parameter int unsigned NUM_STATES   = 256,
  parameter int unsigned NUM_SYMBOLS  = 64,
  parameter int unsigned NUM_PRODS    = 128,
  parameter int unsigned STACK_DEPTH  = 256,
  parameter int unsigned MAX_PROD_LEN = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lrp_cmd_t   cmd_i,
  output lrp_sts_t        sts_o,
  input  wire logic [7:0] state_index_i,
  input  wire logic [5:0] symbol_i,
  input  wire logic [1:0] action_kind_i,
  input  wire logic [7:0] action_target_i,
  input  wire logic [6:0] prod_index_i,
  input  wire logic [3:0] prod_length_i,
  input  wire logic [5:0] prod_lhs_i,
  output logic [2:0]      status_o,
  output logic [7:0]      reductions_o,
  output logic [7:0]      top_state_o
);

  localparam int unsigned ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int unsigned AW  = $clog2(ACT_DEPTH);
  localparam int unsigned PW  = (NUM_PRODS > 1) ? $clog2(NUM_PRODS) : 1;
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 2);

  logic [ENTRY_W-1:0] act_mem  [ACT_DEPTH];
  logic [ENTRY_W-1:0] prod_mem [NUM_PRODS];
  logic [STATE_W-1:0] stk_mem  [STACK_DEPTH];

  logic [ENTRY_W-1:0] act_rdata_q, prod_rdata_q;
  logic [STATE_W-1:0] stk_rdata_q;
  logic               inrange_q;
  logic               pop_zero_q;
  logic [SPW-1:0]     sp_q;
  logic [STATE_W-1:0] top_q;
  logic [7:0]         reds_q;
  logic [5:0]         sym_q, lhs_q;
  logic [2:0]         status_q;
  logic [2:0]         out_status_q;
  logic [7:0]         out_reds_q, out_top_q;

  logic [STATE_W-1:0] pop_top;
  logic [STATE_W-1:0] rd_state;
  logic [5:0]         rd_sym;
  logic               rd_inrange;
  logic               wr_inrange;
  logic [7:0]         act_target;
  logic [3:0]         prod_len;
  logic [SPW-1:0]     sp_pop;
  logic               push_fits;

  function automatic logic [AW-1:0] act_addr(input logic [7:0] st, input logic [5:0] sym);
    logic [AW-1:0] row;
    row = AW'(AW'(st) * AW'(NUM_SYMBOLS));
    return AW'(row + AW'(sym));
  endfunction

  assign pop_top    = pop_zero_q ? '0 : stk_rdata_q;
  assign rd_state   = cmd_i.goto_rd ? pop_top : top_q;
  assign rd_sym     = cmd_i.goto_rd ? lhs_q : sym_q;
  assign rd_inrange = (32'(rd_state) < NUM_STATES) && (32'(rd_sym) < NUM_SYMBOLS);
  assign wr_inrange = (32'(state_index_i) < NUM_STATES) && (32'(symbol_i) < NUM_SYMBOLS);
  assign act_target = act_rdata_q[7:0];
  assign prod_len   = prod_rdata_q[9:6];
  assign sp_pop     = SPW'(sp_q - SPW'(prod_len));
  assign push_fits  = (32'(sp_q) < STACK_DEPTH);

  assign sts_o.kind     = act_rdata_q[9:8];
  assign sts_o.inrange  = inrange_q;
  assign sts_o.sp_full  = !push_fits;
  assign sts_o.reds_cap = (reds_q == REDUCE_CAP);
  assign sts_o.prod_bad = (32'(act_target) >= NUM_PRODS);
  assign sts_o.len_bad  = (32'(prod_len) > MAX_PROD_LEN) || (32'(prod_len) >= 32'(sp_q));

  // Table memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_action && wr_inrange) begin
      act_mem[act_addr(state_index_i, symbol_i)] <= {action_kind_i, action_target_i};
    end
    if (cmd_i.act_rd || cmd_i.goto_rd) begin
      act_rdata_q <= act_mem[act_addr(rd_state, rd_sym)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_prod && (32'(prod_index_i) < NUM_PRODS)) begin
      prod_mem[PW'(prod_index_i)] <= {prod_length_i, prod_lhs_i};
    end
    if (cmd_i.prod_rd) begin
      prod_rdata_q <= prod_mem[PW'(act_target)];
    end
  end

  // Entry 0 is never written; it always reads as state 0 through pop_zero_q.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && push_fits) begin
      stk_mem[SAW'(sp_q)] <= act_target;
    end
    if (cmd_i.pop) begin
      stk_rdata_q <= stk_mem[SAW'(sp_pop - SPW'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act_rd || cmd_i.goto_rd) begin
      inrange_q <= rd_inrange;
    end
    if (cmd_i.pop) begin
      pop_zero_q <= (sp_pop == SPW'(1));
      lhs_q      <= prod_rdata_q[5:0];
    end
    if (cmd_i.latch) begin
      sym_q <= symbol_i;
    end
    if (cmd_i.latch) begin
      status_q <= ST_LOADED;
    end else if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_reds_q   <= reds_q;
      out_top_q    <= top_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= SPW'(1);
      top_q  <= '0;
      reds_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        sp_q  <= SPW'(1);
        top_q <= '0;
      end else if (cmd_i.push) begin
        sp_q  <= SPW'(sp_q + SPW'(1));
        top_q <= act_target;
      end else if (cmd_i.pop) begin
        sp_q <= sp_pop;
      end else if (cmd_i.goto_rd) begin
        top_q <= pop_top;
      end
      if (cmd_i.latch) begin
        reds_q <= '0;
      end else if (cmd_i.count) begin
        reds_q <= reds_q + 8'd1;
      end
    end
  end

  assign status_o     = out_status_q;
  assign reductions_o = out_reds_q;
  assign top_state_o  = out_top_q;

endmodule

`default_nettype wire

// ===== hdl/lr_table_driven_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// LR shift-reduce parse engine with loadable action/goto and production tables.
// Every accepted beat produces one result beat. Table loads and the unused mode
// go from acceptance straight to the final state, which loads the result
// register. A token passes through action read and action evaluation to the
// final state when its first action lookup shifts, accepts or fails; each
// reduction before that walks action lookup, production lookup, stack read and
// goto lookup in turn, since the action memory and the state stack memory each
// have one registered read. The next beat is accepted in the cycle after the
// result is loaded. No clearing pass is needed after reset. A new beat is taken
// while the previous result waits to be collected; the engine only holds in its
// final cycle if that result is still stalled.
module lr_table_driven_parser_core import lrp_pkg::*; #(
  parameter int unsigned NUM_STATES   = 256,
  parameter int unsigned NUM_SYMBOLS  = 64,
  parameter int unsigned NUM_PRODS    = 128,
  parameter int unsigned STACK_DEPTH  = 256,
  parameter int unsigned MAX_PROD_LEN = 15
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] state_index_i,
  input  wire logic [5:0] symbol_i,
  input  wire logic [1:0] action_kind_i,
  input  wire logic [7:0] action_target_i,
  input  wire logic [6:0] prod_index_i,
  input  wire logic [3:0] prod_length_i,
  input  wire logic [5:0] prod_lhs_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      reductions_o,
  output logic [7:0]      top_state_o
);

  lrp_cmd_t cmd;
  lrp_sts_t sts;

  lrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lrp_datapath #(
    .NUM_STATES   (NUM_STATES),
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .NUM_PRODS    (NUM_PRODS),
    .STACK_DEPTH  (STACK_DEPTH),
    .MAX_PROD_LEN (MAX_PROD_LEN)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .state_index_i   (state_index_i),
    .symbol_i        (symbol_i),
    .action_kind_i   (action_kind_i),
    .action_target_i (action_target_i),
    .prod_index_i    (prod_index_i),
    .prod_length_i   (prod_length_i),
    .prod_lhs_i      (prod_lhs_i),
    .status_o        (status_o),
    .reductions_o    (reductions_o),
    .top_state_o     (top_state_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lrp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lrp_checker import lrp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] status_o,
  input wire logic [7:0] reductions_o,
  input wire logic [7:0] top_state_o
);

  // A stalled result beat stays up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(status_o) && $stable(reductions_o) && $stable(top_state_o))
    else $error("stalled result payload changed");

  // Accept, error and overflow leave only state 0 on the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ACCEPTED || status_o == ST_ERROR ||
                    status_o == ST_OVERFLOW) |-> top_state_o == 8'd0)
    else $error("stack not reset after terminal outcome");

  // Loads never perform reductions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_LOADED |-> reductions_o == 8'd0)
    else $error("load reported reductions");

endmodule

bind lr_table_driven_parser_core lrp_checker u_lrp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .reductions_o (reductions_o),
  .top_state_o  (top_state_o)
);

`default_nettype wire
